// File: hw/rtl/maidenhead_locator_encoder_assert.svh
// Assertion macros for the locator encoder checker.
`ifndef MAIDENHEAD_LOCATOR_ENCODER_ASSERT_SVH
`define MAIDENHEAD_LOCATOR_ENCODER_ASSERT_SVH

// Check that cons holds in the cycle after ante.
`define MHL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check that cons holds in the same cycle as ante.
`define MHL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/mhl_pkg.sv
package mhl_pkg;

    localparam int MAX_PAIRS = 5;
    localparam int MAX_RADIX = 24;
    localparam int REM_W     = 35;
    localparam int CHAR_W    = 7;
    localparam int IDX_W     = 3;
    localparam int CNT_W     = 3;
    localparam int RAD_W     = 5;

    localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'd65;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT  = 7'd48;

    typedef struct packed {
        logic                              valid;
        logic [CNT_W-1:0]                  count;
        logic [REM_W-1:0]                  rem_lon;
        logic [REM_W-1:0]                  rem_lat;
        logic [MAX_PAIRS-1:0][CHAR_W-1:0]  lon_chars;
        logic [MAX_PAIRS-1:0][CHAR_W-1:0]  lat_chars;
    } stage_t;

    // Longitude place values in units of 1e-7/9 degree; latitude uses half.
    function automatic logic [REM_W-1:0] lon_step(input logic [IDX_W-1:0] idx);
        logic [REM_W-1:0] s;
        case (idx)
            3'd0:    s = 35'd32400000000;
            3'd1:    s = 35'd1800000000;
            3'd2:    s = 35'd180000000;
            3'd3:    s = 35'd7500000;
            3'd4:    s = 35'd750000;
            default: s = 35'd31250;
        endcase
        return s;
    endfunction

    function automatic logic [RAD_W-1:0] pair_radix(input logic [IDX_W-1:0] idx);
        logic [RAD_W-1:0] r;
        case (idx)
            3'd0:    r = 5'd18;
            3'd2,
            3'd4:    r = 5'd24;
            default: r = 5'd10;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/maidenhead_locator_encoder.sv
// Maidenhead locator encoder.
// Input channel (in_valid/in_stall): one position per transaction, longitude and
// latitude in 1e-7 degree plus the fix quality digit. Output channel
// (out_valid/out_stall): one transaction per locator pair, carrying the
// longitude and latitude characters, the pair position and a last-pair flag.
// Positions without a valid fix, or taken while pair_count is zero, give no
// output. pair_count is written over the APB port at address 0 (saturates at 5).
// A position passes a wrap stage and a row of five digit cells, one cell per
// pair, then lands in the pair buffer, which shows the pairs one per cycle while
// out_stall is low. Up to seven positions are in flight; the pair buffer takes
// the next position with a valid fix only as the last pair of the one before is
// taken, and a dropped position never enters it.
// While out_stall is high the current pair holds, the cell row freezes and
// in_stall rises once the row cannot move. Reset empties the row and the buffer
// and sets pair_count to 3.
module maidenhead_locator_encoder
    import mhl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  longitude,
    input  logic signed [30:0]  latitude,
    input  logic [3:0]          fix_quality,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [CHAR_W-1:0]   lon_char,
    output logic [CHAR_W-1:0]   lat_char,
    output logic [IDX_W-1:0]    pair_index,
    output logic                last_pair
);

    localparam logic             CFG_PAIR_COUNT = 1'b0;
    localparam logic [CNT_W-1:0] PAIR_LIMIT     = 3'd5;
    localparam logic [CNT_W-1:0] PAIR_RESET     = 3'd3;

    logic [CNT_W-1:0] pair_count_reg;
    logic [CNT_W-1:0] pair_count_next;
    logic             cfg_write;
    logic             adv;
    logic             accept;
    stage_t           chain [MAX_PAIRS+1];

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == CFG_PAIR_COUNT);

    always_comb
    begin
        if (pwdata > 32'(PAIR_LIMIT))
        begin
            pair_count_next = PAIR_LIMIT;
        end
        else
        begin
            pair_count_next = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_count_reg <= PAIR_RESET;
        end
        else if (cfg_write)
        begin
            pair_count_reg <= pair_count_next;
        end
    end

    assign prdata   = (paddr[2] == CFG_PAIR_COUNT) ? 32'(pair_count_reg) : '0;
    assign in_stall = !adv;
    assign accept   = in_valid && !in_stall;

    mhl_wrap u_wrap (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .accept      (accept),
        .longitude   (longitude),
        .latitude    (latitude),
        .fix_quality (fix_quality),
        .pair_count  (pair_count_reg),
        .stage_out   (chain[0])
    );

    for (genvar g = 0; g < MAX_PAIRS; g++)
    begin : g_cell
        mhl_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .cell_idx  (IDX_W'(g)),
            .stage_in  (chain[g]),
            .stage_out (chain[g+1])
        );
    end

    mhl_serial u_serial (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage_in   (chain[MAX_PAIRS]),
        .out_stall  (out_stall),
        .adv        (adv),
        .out_valid  (out_valid),
        .lon_char   (lon_char),
        .lat_char   (lat_char),
        .pair_index (pair_index),
        .last_pair  (last_pair)
    );

endmodule

// File: hw/rtl/mhl_wrap.sv
module mhl_wrap
    import mhl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                accept,
    input  logic signed [31:0]  longitude,
    input  logic signed [30:0]  latitude,
    input  logic [3:0]          fix_quality,
    input  logic [CNT_W-1:0]    pair_count,
    output stage_t              stage_out
);

    localparam logic [3:0]          FIX_VALID  = 4'd1;
    localparam logic signed [33:0]  LON_OFFSET = 34'sd1800000000;
    localparam logic signed [33:0]  LON_SPAN   = 34'sd3600000000;
    localparam logic signed [32:0]  LAT_OFFSET = 33'sd900000000;
    localparam logic signed [32:0]  LAT_SPAN   = 33'sd1800000000;

    logic signed [33:0] lon_s;
    logic signed [32:0] lat_s;
    logic [31:0]        lon_r;
    logic [30:0]        lat_r;
    logic               valid_reg;
    logic               valid_next;
    stage_t             stage_reg;
    stage_t             stage_next;

    always_comb
    begin
        lon_s = 34'(longitude) + LON_OFFSET;
        if (lon_s < 0)
        begin
            lon_s = lon_s + LON_SPAN;
        end
        else if (lon_s >= LON_SPAN)
        begin
            lon_s = lon_s - LON_SPAN;
        end
        lon_r = lon_s[31:0];

        lat_s = 33'(latitude) + LAT_OFFSET;
        if (lat_s < 0)
        begin
            lat_s = lat_s + LAT_SPAN;
        end
        else if (lat_s >= LAT_SPAN)
        begin
            lat_s = lat_s - LAT_SPAN;
        end
        lat_r = lat_s[30:0];

        stage_next           = '0;
        stage_next.count     = pair_count;
        // scale by nine so every place value is a whole number
        stage_next.rem_lon   = (REM_W'(lon_r) << 3) + REM_W'(lon_r);
        stage_next.rem_lat   = (REM_W'(lat_r) << 3) + REM_W'(lat_r);
        stage_next.valid     = accept && (fix_quality == FIX_VALID) && (pair_count != '0);
        valid_next           = stage_next.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stage_reg <= stage_next;
        end
    end

    always_comb
    begin
        stage_out       = stage_reg;
        stage_out.valid = valid_reg;
    end

endmodule

// File: hw/rtl/mhl_cell.sv
module mhl_cell
    import mhl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic [IDX_W-1:0]   cell_idx,
    input  stage_t             stage_in,
    output stage_t             stage_out
);

    logic [REM_W-1:0]  lon_div;
    logic [REM_W-1:0]  lat_div;
    logic [REM_W-1:0]  lon_mult;
    logic [REM_W-1:0]  lat_mult;
    logic [REM_W-1:0]  lon_sel;
    logic [REM_W-1:0]  lat_sel;
    logic [CHAR_W-1:0] lon_dig;
    logic [CHAR_W-1:0] lat_dig;
    logic [CHAR_W-1:0] base;
    logic [RAD_W-1:0]  rad;
    logic              valid_reg;
    stage_t            stage_reg;
    stage_t            stage_next;

    // digit = largest multiple of the next place value that fits the remainder
    always_comb
    begin
        lon_div = lon_step(IDX_W'(cell_idx + 1'b1));
        lat_div = lon_div >> 1;
        rad     = pair_radix(cell_idx);
        base    = cell_idx[0] ? CHAR_DIGIT : CHAR_LETTER;
        lon_dig = '0;
        lat_dig = '0;
        lon_sel = '0;
        lat_sel = '0;
        for (int k = 1; k < MAX_RADIX; k++)
        begin
            lon_mult = REM_W'(64'(k) * 64'(lon_div));
            lat_mult = REM_W'(64'(k) * 64'(lat_div));
            if ((RAD_W'(k) < rad) && (stage_in.rem_lon >= lon_mult))
            begin
                lon_dig = CHAR_W'(k);
                lon_sel = lon_mult;
            end
            if ((RAD_W'(k) < rad) && (stage_in.rem_lat >= lat_mult))
            begin
                lat_dig = CHAR_W'(k);
                lat_sel = lat_mult;
            end
        end

        stage_next                     = stage_in;
        stage_next.rem_lon             = stage_in.rem_lon - lon_sel;
        stage_next.rem_lat             = stage_in.rem_lat - lat_sel;
        stage_next.lon_chars[cell_idx] = base + lon_dig;
        stage_next.lat_chars[cell_idx] = base + lat_dig;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stage_reg <= stage_next;
        end
    end

    always_comb
    begin
        stage_out       = stage_reg;
        stage_out.valid = valid_reg;
    end

endmodule

// File: hw/rtl/mhl_serial.sv
module mhl_serial
    import mhl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  stage_t             stage_in,
    input  logic               out_stall,
    output logic               adv,
    output logic               out_valid,
    output logic [CHAR_W-1:0]  lon_char,
    output logic [CHAR_W-1:0]  lat_char,
    output logic [IDX_W-1:0]   pair_index,
    output logic               last_pair
);

    logic                             valid_reg;
    logic                             valid_next;
    logic [IDX_W-1:0]                 idx_reg;
    logic [CNT_W-1:0]                 count_reg;
    logic [MAX_PAIRS-1:0][CHAR_W-1:0] lon_sh_reg;
    logic [MAX_PAIRS-1:0][CHAR_W-1:0] lat_sh_reg;
    logic                             take;
    logic                             is_last;
    logic                             done;
    logic                             load;

    always_comb
    begin
        take    = valid_reg && !out_stall;
        is_last = (idx_reg == IDX_W'(count_reg - 1'b1));
        done    = take && is_last;
        // the chain moves only when the pair buffer can take its next locator
        adv     = !valid_reg || done;
        load    = adv && stage_in.valid;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (done)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            idx_reg    <= '0;
            count_reg  <= stage_in.count;
            lon_sh_reg <= stage_in.lon_chars;
            lat_sh_reg <= stage_in.lat_chars;
        end
        else if (take)
        begin
            idx_reg    <= IDX_W'(idx_reg + 1'b1);
            lon_sh_reg <= {CHAR_W'(0), lon_sh_reg[MAX_PAIRS-1:1]};
            lat_sh_reg <= {CHAR_W'(0), lat_sh_reg[MAX_PAIRS-1:1]};
        end
    end

    assign out_valid  = valid_reg;
    assign lon_char   = lon_sh_reg[0];
    assign lat_char   = lat_sh_reg[0];
    assign pair_index = idx_reg;
    assign last_pair  = is_last;

endmodule

// File: hw/rtl/mhl_checker.sv
`include "maidenhead_locator_encoder_assert.svh"

module mhl_checker
    import mhl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [CHAR_W-1:0] lon_char,
    input  logic [CHAR_W-1:0] lat_char,
    input  logic [IDX_W-1:0]  pair_index,
    input  logic              last_pair
);

    `MHL_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(lon_char) && $stable(lat_char) && $stable(pair_index) && $stable(last_pair), "stalled pair changed")
    `MHL_ASSERT_NEXT(a_pair_advance, out_valid && !out_stall && !last_pair, out_valid && (pair_index == IDX_W'($past(pair_index) + 1'b1)), "pair sequence broken")
    `MHL_ASSERT_NEXT(a_new_locator, out_valid && !out_stall && last_pair, !out_valid || (pair_index == '0), "locator does not restart at field pair")
    `MHL_ASSERT_NOW(a_final_pair, out_valid && (pair_index == IDX_W'(MAX_PAIRS - 1)), last_pair, "final pair position not marked last")

endmodule

bind maidenhead_locator_encoder mhl_checker u_checker (.*);
